// ===== rtl/fsp_pkg.sv =====
// Shared constants, codes and divider request/response types for the frame sequence player.
package fsp_pkg;

	localparam int MAX_FRAMES = 256;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int COUNT_W    = FRAME_W + 1;
	localparam int DUR_W      = 32;
	localparam int SPEED_W    = 16;
	localparam int MODE_W     = 2;
	localparam int DT_W       = 24;
	localparam int ACT_W      = 3;
	localparam int ELAP_W     = 33;
	localparam int COMP_W     = 8;
	localparam int PROD_W     = DT_W + SPEED_W;
	localparam int SUM_W      = COUNT_W + DUR_W;
	localparam int PER_W      = SUM_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int IN_BITS    = ACT_W + DT_W + FRAME_W + DUR_W;
	localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = FRAME_W + 3 + COMP_W + ELAP_W;
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [ACT_W-1:0] ACT_TICK    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PAUSE   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_STOP    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;
	localparam logic [ACT_W-1:0] ACT_SETPOS  = 3'd5;
	localparam logic [ACT_W-1:0] ACT_WRDUR   = 3'd6;

	localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ONCE_RST = 2'd2;
	localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DUR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 2'd3;

	localparam logic [COUNT_W-1:0] RST_FRAME_COUNT = 9'd1;
	localparam logic [DUR_W-1:0]   RST_DEFAULT_DUR = 32'd6554;
	localparam logic [SPEED_W-1:0] RST_SPEED       = 16'd256;

	typedef struct packed {
		logic              start;
		logic [ELAP_W-1:0] dividend;
		logic [ELAP_W-1:0] divisor;
	} fsp_div_req_t;

	typedef struct packed {
		logic              done;
		logic [ELAP_W-1:0] rem;
		logic [COMP_W-1:0] quot;
	} fsp_div_rsp_t;

endpackage

// ===== rtl/frame_sequence_player.sv =====
// Frame sequence player top level: command sequencer around the frame duration memory.
//
//  channel   | direction | handshake         | payload
//  s_*       | in        | s_tvalid/s_tready | action, dt, frame_index, duration_value
//  m_*       | out       | m_tvalid/m_tready | frame, flags, completions, elapsed time
//  cfg_*     | in        | cfg_we            | cfg_index, cfg_wdata
//
// Control items go straight to the result; duration writes pass through a RAM write first. A tick
// multiplies and accumulates, then in loop and ping-pong mode (ping-pong after reading the end frames)
// may run the divider to remove whole periods, then steps frames; a paused tick steps no frame.
// A frame count write holds s_tready low while the written durations are re-summed.
// Reset clears state and written marks; memory contents are not cleared.
// A waiting result blocks the next item until its slot is taken.
module frame_sequence_player (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// action[2:0], dt[26:3], frame_index[34:27], duration_value[66:35], zero fill
	input  logic [fsp_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// frame[7:0], playing[8], finished[9], reverse[10], completions[18:11],
	// elapsed_out[51:19], zero fill
	output logic [fsp_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           cfg_we,
	input  logic [fsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import fsp_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SWEEP = 4'd1;
	localparam logic [3:0] S_WR    = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_ADD   = 4'd4;
	localparam logic [3:0] S_RD0   = 4'd5;
	localparam logic [3:0] S_RD1   = 4'd6;
	localparam logic [3:0] S_PP    = 4'd7;
	localparam logic [3:0] S_CHK   = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_SRD   = 4'd10;
	localparam logic [3:0] S_SCMP  = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	function automatic logic [COUNT_W-1:0] eff_of(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = COUNT_W'(1);
		end else if (c > COUNT_W'(MAX_FRAMES)) begin
			r = COUNT_W'(MAX_FRAMES);
		end
		return r;
	endfunction

	// configuration
	logic [COUNT_W-1:0] cnt_q;
	logic [DUR_W-1:0]   defd_q;
	logic [SPEED_W-1:0] speed_q;
	logic [MODE_W-1:0]  mode_q;

	// playback state
	logic [3:0]            state_q;
	logic [ELAP_W-1:0]     elapsed_q;
	logic [FRAME_W-1:0]    pos_q;
	logic                  playing_q;
	logic                  finished_q;
	logic                  rev_q;
	logic [MAX_FRAMES-1:0] written_q;
	logic [SUM_W-1:0]      wsum_q;
	logic [COUNT_W-1:0]    wcnt_q;
	logic [COMP_W-1:0]     total_q;
	logic                  sweep_pend_q;
	logic [COUNT_W-1:0]    sweep_i_q;
	logic                  sweep_v_s1;
	logic                  sweep_w_s1;
	logic                  out_v_q;
	logic [OUT_W-1:0]      out_q;

	// item and working registers
	logic [DT_W-1:0]    dt_q;
	logic [FRAME_W-1:0] idx_q;
	logic [DUR_W-1:0]   val_q;
	logic [PROD_W-1:0]  prod_q;
	logic [SUM_W-1:0]   dm_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PER_W-1:0]   period_q;
	logic [DUR_W-1:0]   d0_q;

	logic [ACT_W-1:0]   in_action;
	logic [DT_W-1:0]    in_dt;
	logic [FRAME_W-1:0] in_idx;
	logic [DUR_W-1:0]   in_val;
	logic               accept;

	logic [COUNT_W-1:0] eff_n;
	logic [COUNT_W-1:0] nm1_full;
	logic [COUNT_W-1:0] nm2_full;
	logic [FRAME_W-1:0] nm1;
	logic [DUR_W-1:0]   def_eff;
	logic [COUNT_W-1:0] new_eff;
	logic [COUNT_W-1:0] new_nm1;
	logic [COUNT_W-1:0] unw;
	logic [SUM_W-1:0]   dm_full;
	logic [PROD_W-1:0]  prod_full;
	logic [ELAP_W:0]    elap_sum;
	logic [ELAP_W-1:0]  elap_sat;
	logic [SUM_W-1:0]   sum_now;
	logic [DUR_W-1:0]   cur_dur;
	logic [DUR_W-1:0]   dn1;
	logic [DUR_W-1:0]   old_dur;
	logic [COMP_W-1:0]  div_total;

	logic [COUNT_W-1:0] fwd_next;
	logic [FRAME_W-1:0] adv_pos;
	logic               adv_rev;
	logic               adv_end;
	logic               adv_done;
	logic               over;
	logic               under;

	logic               ram_we;
	logic [FRAME_W-1:0] ram_raddr;
	logic [DUR_W-1:0]   ram_rdata;

	fsp_div_req_t div_req;
	fsp_div_rsp_t div_rsp;

	assign in_action = s_tdata[ACT_W-1:0];
	assign in_dt     = s_tdata[ACT_W +: DT_W];
	assign in_idx    = s_tdata[ACT_W+DT_W +: FRAME_W];
	assign in_val    = s_tdata[ACT_W+DT_W+FRAME_W +: DUR_W];

	assign s_tready = (state_q == S_IDLE) && !sweep_pend_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	assign eff_n    = eff_of(cnt_q);
	assign nm1_full = eff_n - COUNT_W'(1);
	assign nm2_full = eff_n - COUNT_W'(2);
	assign nm1      = nm1_full[FRAME_W-1:0];
	assign def_eff  = (defd_q == '0) ? DUR_W'(1) : defd_q;
	assign new_eff  = eff_of(cfg_wdata[COUNT_W-1:0]);
	assign new_nm1  = new_eff - COUNT_W'(1);

	assign unw       = eff_n - wcnt_q;
	assign dm_full   = unw * def_eff;
	assign prod_full = dt_q * speed_q;
	assign elap_sum  = {1'b0, elapsed_q} + (ELAP_W+1)'(prod_q[PROD_W-1:8]);
	assign elap_sat  = elap_sum[ELAP_W] ? '1 : elap_sum[ELAP_W-1:0];
	assign sum_now   = wsum_q + dm_q;

	assign cur_dur = written_q[pos_q] ? ram_rdata : def_eff;
	assign dn1     = written_q[nm1] ? ram_rdata : def_eff;
	assign old_dur = written_q[idx_q] ? ram_rdata : '0;

	// completions from whole periods removed by the divider
	always_comb begin
		div_total = '0;
		if (mode_q == MODE_PINGPONG) begin
			div_total = div_rsp.quot[COMP_W-1] ? '1 : {div_rsp.quot[COMP_W-2:0], 1'b0};
		end else if (!rev_q) begin
			div_total = div_rsp.quot;
		end
	end

	// one frame move in the present mode and direction
	always_comb begin
		fwd_next = {1'b0, pos_q} + COUNT_W'(1);
		over     = !rev_q && (fwd_next >= eff_n);
		under    = rev_q && (pos_q == '0);
		adv_pos  = rev_q ? pos_q - FRAME_W'(1) : fwd_next[FRAME_W-1:0];
		adv_rev  = rev_q;
		adv_end  = 1'b0;
		adv_done = 1'b0;
		case (mode_q)
			MODE_LOOP: begin
				if (over) begin
					adv_pos  = '0;
					adv_done = 1'b1;
				end else if (under) begin
					adv_pos = nm1;
				end
			end
			MODE_ONCE: begin
				if (over) begin
					adv_pos  = nm1;
					adv_end  = 1'b1;
					adv_done = 1'b1;
				end else if (under) begin
					adv_pos = '0;
					adv_end = 1'b1;
				end
			end
			MODE_ONCE_RST: begin
				if (over || under) begin
					adv_pos  = '0;
					adv_end  = 1'b1;
					adv_done = 1'b1;
				end
			end
			default: begin
				if (over) begin
					adv_rev  = 1'b1;
					adv_pos  = (eff_n >= COUNT_W'(2)) ? nm2_full[FRAME_W-1:0] : '0;
					adv_done = 1'b1;
				end else if (under) begin
					adv_rev  = 1'b0;
					adv_pos  = (eff_n >= COUNT_W'(2)) ? FRAME_W'(1) : '0;
					adv_done = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		case (state_q)
			S_IDLE:  ram_raddr = in_idx;
			S_SWEEP: ram_raddr = sweep_i_q[FRAME_W-1:0];
			S_RD1:   ram_raddr = nm1;
			S_SRD:   ram_raddr = pos_q;
			default: ram_raddr = '0;
		endcase
	end

	assign ram_we = (state_q == S_WR);

	assign div_req.start    = (state_q == S_CHK) && (period_q <= PER_W'(elapsed_q));
	assign div_req.dividend = elapsed_q;
	assign div_req.divisor  = period_q[ELAP_W-1:0];

	fsp_ram #(
		.WIDTH (DUR_W),
		.DEPTH (MAX_FRAMES)
	) u_dur_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (val_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fsp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q  <= in_dt;
			idx_q <= in_idx;
			val_q <= in_val;
		end
		if (state_q == S_MUL) begin
			prod_q <= prod_full;
			dm_q   <= dm_full;
		end
		if (state_q == S_ADD) begin
			sum_q    <= sum_now;
			period_q <= {1'b0, sum_now};
		end
		if (state_q == S_RD1) begin
			d0_q <= written_q[0] ? ram_rdata : def_eff;
		end
		if (state_q == S_PP) begin
			if (eff_n == COUNT_W'(1)) begin
				period_q <= {sum_q, 1'b0};
			end else begin
				period_q <= {sum_q, 1'b0} - PER_W'(d0_q) - PER_W'(dn1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= RST_FRAME_COUNT;
			defd_q       <= RST_DEFAULT_DUR;
			speed_q      <= RST_SPEED;
			mode_q       <= MODE_LOOP;
			state_q      <= S_IDLE;
			elapsed_q    <= '0;
			pos_q        <= '0;
			playing_q    <= 1'b0;
			finished_q   <= 1'b0;
			rev_q        <= 1'b0;
			written_q    <= '0;
			wsum_q       <= '0;
			wcnt_q       <= '0;
			total_q      <= '0;
			sweep_pend_q <= 1'b0;
			sweep_i_q    <= '0;
			sweep_v_s1   <= 1'b0;
			sweep_w_s1   <= 1'b0;
			out_v_q      <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sweep_pend_q) begin
						sweep_pend_q <= 1'b0;
						sweep_i_q    <= '0;
						sweep_v_s1   <= 1'b0;
						wsum_q       <= '0;
						wcnt_q       <= '0;
						state_q      <= S_SWEEP;
					end else if (accept) begin
						total_q <= '0;
						state_q <= S_OUT;
						case (in_action)
							ACT_TICK: begin
								if (playing_q && !finished_q) begin
									state_q <= S_MUL;
								end
							end
							ACT_PLAY: begin
								playing_q  <= 1'b1;
								finished_q <= 1'b0;
							end
							ACT_PAUSE: begin
								playing_q <= 1'b0;
							end
							ACT_STOP, ACT_RESTART: begin
								playing_q  <= (in_action == ACT_RESTART);
								finished_q <= 1'b0;
								rev_q      <= 1'b0;
								pos_q      <= '0;
								elapsed_q  <= '0;
							end
							ACT_SETPOS: begin
								pos_q     <= ({1'b0, in_idx} >= eff_n) ? nm1 : in_idx;
								elapsed_q <= '0;
							end
							ACT_WRDUR: begin
								// read the old entry so the written sum can drop it
								if (({1'b0, in_idx} < eff_n) && (in_val != '0)) begin
									state_q <= S_WR;
								end
							end
							default: ;
						endcase
					end
				end
				S_SWEEP: begin
					if (sweep_v_s1 && sweep_w_s1) begin
						wsum_q <= wsum_q + SUM_W'(ram_rdata);
						wcnt_q <= wcnt_q + COUNT_W'(1);
					end
					if (sweep_i_q < eff_n) begin
						sweep_v_s1 <= 1'b1;
						sweep_w_s1 <= written_q[sweep_i_q[FRAME_W-1:0]];
						sweep_i_q  <= sweep_i_q + COUNT_W'(1);
					end else begin
						sweep_v_s1 <= 1'b0;
						if (!sweep_v_s1) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_WR: begin
					wsum_q           <= wsum_q - SUM_W'(old_dur) + SUM_W'(val_q);
					wcnt_q           <= wcnt_q + COUNT_W'(!written_q[idx_q]);
					written_q[idx_q] <= 1'b1;
					state_q          <= S_OUT;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					elapsed_q <= elap_sat;
					case (mode_q)
						MODE_LOOP:     state_q <= S_CHK;
						MODE_PINGPONG: state_q <= S_RD0;
						default:       state_q <= S_SRD;
					endcase
				end
				S_RD0: begin
					state_q <= S_RD1;
				end
				S_RD1: begin
					state_q <= S_PP;
				end
				S_PP: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= div_req.start ? S_DIV : S_SRD;
				end
				S_DIV: begin
					if (div_rsp.done) begin
						elapsed_q <= div_rsp.rem;
						total_q   <= div_total;
						state_q   <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= finished_q ? S_OUT : S_SCMP;
				end
				S_SCMP: begin
					if (elapsed_q >= ELAP_W'(cur_dur)) begin
						elapsed_q <= elapsed_q - ELAP_W'(cur_dur);
						pos_q     <= adv_pos;
						rev_q     <= adv_rev;
						if (adv_end) begin
							finished_q <= 1'b1;
							playing_q  <= 1'b0;
						end
						if (total_q != '1) begin
							total_q <= total_q + COMP_W'(adv_done);
						end
						state_q <= S_SRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the result slot is free
					if (!out_v_q || m_tready) begin
						out_v_q <= 1'b1;
						out_q   <= OUT_W'({elapsed_q, total_q, rev_q, finished_q,
							playing_q, pos_q});
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_COUNT: begin
						cnt_q        <= cfg_wdata[COUNT_W-1:0];
						sweep_pend_q <= 1'b1;
						if ({1'b0, pos_q} >= new_eff) begin
							pos_q <= new_nm1[FRAME_W-1:0];
						end
					end
					REG_DEFAULT_DUR: defd_q  <= cfg_wdata[DUR_W-1:0];
					REG_SPEED:       speed_q <= cfg_wdata[SPEED_W-1:0];
					REG_PLAY_MODE:   mode_q  <= cfg_wdata[MODE_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== rtl/fsp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module fsp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fsp_div.sv =====
// Iterative restoring divider: remainder and saturated quotient, one bit per cycle.
module fsp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsp_pkg::fsp_div_req_t req,
	output fsp_pkg::fsp_div_rsp_t rsp
);
	import fsp_pkg::*;

	localparam int ITER_W = $clog2(ELAP_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [ELAP_W-1:0] rem_q;
	logic [ELAP_W-1:0] dvd_q;
	logic [ELAP_W-1:0] dsr_q;
	logic [COMP_W-1:0] quo_q;
	logic              ovf_q;

	logic [ELAP_W:0]   shifted;
	logic [ELAP_W:0]   diff;
	logic              ge;
	logic [COMP_W:0]   quo_next;

	assign shifted  = {rem_q, dvd_q[ELAP_W-1]};
	assign ge       = shifted >= {1'b0, dsr_q};
	assign diff     = shifted - {1'b0, dsr_q};
	assign quo_next = {quo_q, ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(ELAP_W);
				rem_q  <= '0;
				dvd_q  <= req.dividend;
				dsr_q  <= req.divisor;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
			end else if (busy_q) begin
				// remainder stays below the divisor, so it fits the dividend width
				rem_q  <= ge ? diff[ELAP_W-1:0] : shifted[ELAP_W-1:0];
				dvd_q  <= {dvd_q[ELAP_W-2:0], 1'b0};
				quo_q  <= quo_next[COMP_W-1:0];
				ovf_q  <= ovf_q | quo_next[COMP_W];
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quot = ovf_q ? '1 : quo_q;

endmodule
